### src/sbm_pkg.sv
// Package with opcode, status and state types for the stack bytecode machine.
`timescale 1ns / 1ps

package sbm_pkg;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_POP   = 8'd2;
  localparam logic [7:0] OP_ADD   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_MUL   = 8'd5;
  localparam logic [7:0] OP_DIV   = 8'd6;
  localparam logic [7:0] OP_DUP   = 8'd7;
  localparam logic [7:0] OP_JMP   = 8'd8;
  localparam logic [7:0] OP_JZ    = 8'd9;
  localparam logic [7:0] OP_EMIT  = 8'd10;
  localparam logic [7:0] OP_LOAD  = 8'd11;
  localparam logic [7:0] OP_SAVE  = 8'd12;
  localparam logic [7:0] OP_HALT  = 8'd255;

  localparam logic [3:0] ST_RUNNING   = 4'd0;
  localparam logic [3:0] ST_HALTED    = 4'd1;
  localparam logic [3:0] ST_TRUNCATED = 4'd2;
  localparam logic [3:0] ST_OVERFLOW  = 4'd3;
  localparam logic [3:0] ST_UNDERFLOW = 4'd4;
  localparam logic [3:0] ST_BAD_JUMP  = 4'd5;
  localparam logic [3:0] ST_BAD_INDEX = 4'd6;
  localparam logic [3:0] ST_UNKNOWN   = 4'd7;
  localparam logic [3:0] ST_LIMIT     = 4'd8;
  localparam logic [3:0] ST_NO_HALT   = 4'd9;
  localparam logic [3:0] ST_DIV_ZERO  = 4'd10;

  localparam logic REG_PROGRAM_LENGTH = 1'b0;
  localparam logic REG_STEP_LIMIT     = 1'b1;

  localparam logic [8:0]  PROGRAM_LENGTH_RESET = 9'd256;
  localparam logic [15:0] STEP_LIMIT_RESET     = 16'd100;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_OUT
  } state_t;

endpackage

### src/sbm_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module sbm_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic        negate;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        count  <= 6'd32;
        rem    <= 32'd0;
        quo    <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs    <= divisor[31] ? (32'd0 - divisor) : divisor;
        negate <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        // Restoring step: shift in the next dividend bit and try a subtraction.
        if (!trial[32]) begin
          rem <= trial[31:0];
        end else begin
          rem <= {rem[30:0], quo[31]};
        end
        quo   <= {quo[30:0], ~trial[32]};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = negate ? (32'd0 - quo) : quo;

endmodule

### src/stack_bytecode_machine.sv
// Top level of the stack bytecode machine: control, stack memory and data memory.
`timescale 1ns / 1ps

// Executes one bytecode instruction per accepted request and returns one result per request.
// An instruction passes from one accepted request to the next through the request state, two
// stack reads (top, then second), execute, write back, and the result state. A machine that is
// already stopped skips the write back, and DIV adds a wait in the bit-serial divider between
// execute and write back. A result that waits for out_ready holds off the next request. The
// stack and the data words live in synchronous memories with registered reads. After reset
// the data memory is cleared one word per cycle while no request is accepted.
module stack_bytecode_machine #(
  parameter int STACK_DEPTH   = 64,
  parameter int DATA_DEPTH    = 256,
  parameter int PROGRAM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  next_address,
  output logic        print_valid,
  output logic signed [31:0] print_value,
  output logic [3:0]  status,
  output logic        stopped
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam logic [SPW-1:0] STACK_FULL = SPW'(STACK_DEPTH);
  localparam logic [8:0] DATA_LIMIT = 9'(DATA_DEPTH);
  localparam logic [8:0] PROGRAM_LIMIT = 9'(PROGRAM_DEPTH);

  sbm_pkg::state_t state, state_next;

  logic [8:0]     program_length;
  logic [15:0]    step_limit;
  logic [8:0]     ip;
  logic [SPW-1:0] sp;
  logic [15:0]    step_count;
  logic [3:0]     final_status;
  logic [7:0]     op;
  logic [7:0]     arg;
  logic [DAW-1:0] clear_addr;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] data_mem [DATA_DEPTH];
  logic [31:0] top_q;
  logic [31:0] second_q;
  logic [31:0] data_q;

  // Top and second entries are read one after the other through the same port.
  logic        read_phase;
  logic        stack_we;
  logic [SAW-1:0] stack_waddr;
  logic [31:0] stack_wdata;
  logic        data_we;
  logic [DAW-1:0] data_waddr;
  logic [31:0] data_wdata;

  logic [8:0]  len;
  logic [31:0] result;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quotient;

  assign len = (program_length < PROGRAM_LIMIT) ? program_length : PROGRAM_LIMIT;

  sbm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (second_q),
    .divisor  (top_q),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Stack memory: the read address is chosen by the read phase.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (state == sbm_pkg::S_READ && !read_phase) begin
      top_q <= stack_mem[SAW'(sp - SPW'(1))];
    end
    if (state == sbm_pkg::S_READ && read_phase) begin
      second_q <= stack_mem[SAW'(sp - SPW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (state == sbm_pkg::S_READ) begin
      data_q <= data_mem[DAW'(arg)];
    end
  end

  // Execution: status evaluation in the execute state.
  logic [3:0]     exec_status;
  logic [8:0]     ip_next;
  logic [SPW-1:0] sp_next;
  logic           pv_next;
  logic           need2;
  logic           in_data_range;

  always_comb begin
    need2 = (op == sbm_pkg::OP_PUSH) || (op == sbm_pkg::OP_JMP) || (op == sbm_pkg::OP_JZ) ||
            (op == sbm_pkg::OP_LOAD) || (op == sbm_pkg::OP_SAVE);
    in_data_range = {1'b0, arg} < DATA_LIMIT;
    exec_status = sbm_pkg::ST_RUNNING;
    ip_next = ip;
    sp_next = sp;
    pv_next = 1'b0;
    result  = 32'd0;
    if (op > sbm_pkg::OP_SAVE && op != sbm_pkg::OP_HALT) begin
      exec_status = sbm_pkg::ST_UNKNOWN;
    end else if ((10'(ip) + (need2 ? 10'd2 : 10'd1)) > 10'(len)) begin
      exec_status = sbm_pkg::ST_TRUNCATED;
    end else begin
      case (op)
        sbm_pkg::OP_NOP: ip_next = ip + 9'd1;
        sbm_pkg::OP_PUSH: begin
          if (sp >= STACK_FULL) exec_status = sbm_pkg::ST_OVERFLOW;
          else begin
            result = {24'd0, arg}; sp_next = sp + SPW'(1); ip_next = ip + 9'd2;
          end
        end
        sbm_pkg::OP_POP: begin
          if (sp < SPW'(1)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else begin sp_next = sp - SPW'(1); ip_next = ip + 9'd1; end
        end
        sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL, sbm_pkg::OP_DIV: begin
          if (sp < SPW'(2)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else if (op == sbm_pkg::OP_DIV && top_q == 32'd0) exec_status = sbm_pkg::ST_DIV_ZERO;
          else begin
            case (op)
              sbm_pkg::OP_ADD: result = second_q + top_q;
              sbm_pkg::OP_SUB: result = second_q - top_q;
              sbm_pkg::OP_MUL: result = second_q * top_q;
              default:         result = div_quotient;
            endcase
            sp_next = sp - SPW'(1); ip_next = ip + 9'd1;
          end
        end
        sbm_pkg::OP_DUP: begin
          if (sp < SPW'(1)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else if (sp >= STACK_FULL) exec_status = sbm_pkg::ST_OVERFLOW;
          else begin result = top_q; sp_next = sp + SPW'(1); ip_next = ip + 9'd1; end
        end
        sbm_pkg::OP_JMP: begin
          if ({1'b0, arg} >= len) exec_status = sbm_pkg::ST_BAD_JUMP;
          else ip_next = {1'b0, arg};
        end
        sbm_pkg::OP_JZ: begin
          if ({1'b0, arg} >= len) exec_status = sbm_pkg::ST_BAD_JUMP;
          else if (sp < SPW'(1)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else begin
            sp_next = sp - SPW'(1);
            ip_next = (top_q == 32'd0) ? {1'b0, arg} : ip + 9'd2;
          end
        end
        sbm_pkg::OP_EMIT: begin
          if (sp < SPW'(1)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else begin pv_next = 1'b1; sp_next = sp - SPW'(1); ip_next = ip + 9'd1; end
        end
        sbm_pkg::OP_LOAD: begin
          if (!in_data_range) exec_status = sbm_pkg::ST_BAD_INDEX;
          else if (sp >= STACK_FULL) exec_status = sbm_pkg::ST_OVERFLOW;
          else begin result = data_q; sp_next = sp + SPW'(1); ip_next = ip + 9'd2; end
        end
        sbm_pkg::OP_SAVE: begin
          if (!in_data_range) exec_status = sbm_pkg::ST_BAD_INDEX;
          else if (sp < SPW'(1)) exec_status = sbm_pkg::ST_UNDERFLOW;
          else begin sp_next = sp - SPW'(1); ip_next = ip + 9'd2; end
        end
        default: exec_status = sbm_pkg::ST_HALTED;
      endcase
    end
  end

  // Control sequencer.
  logic is_div;
  assign is_div = (op == sbm_pkg::OP_DIV) && (sp >= SPW'(2)) && (top_q != 32'd0) &&
                  (exec_status != sbm_pkg::ST_UNKNOWN) && (exec_status != sbm_pkg::ST_TRUNCATED);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      sbm_pkg::S_CLEAR: if (clear_addr == DAW'(DATA_DEPTH - 1)) state_next = sbm_pkg::S_IDLE;
      sbm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = sbm_pkg::S_READ;
      end
      sbm_pkg::S_READ: if (read_phase) state_next = sbm_pkg::S_EXEC;
      sbm_pkg::S_EXEC: begin
        if (final_status != sbm_pkg::ST_RUNNING || ip >= len || step_count >= step_limit) begin
          state_next = sbm_pkg::S_OUT;
        end else if (is_div) begin
          div_start = 1'b1;
          state_next = sbm_pkg::S_DIV;
        end else begin
          state_next = sbm_pkg::S_WRITE;
        end
      end
      sbm_pkg::S_DIV: if (div_done) state_next = sbm_pkg::S_WRITE;
      sbm_pkg::S_WRITE: state_next = sbm_pkg::S_OUT;
      sbm_pkg::S_OUT: if (out_ready) state_next = sbm_pkg::S_IDLE;
      default: state_next = sbm_pkg::S_IDLE;
    endcase
  end

  // Writes to the memories happen in the write state, or during the clearing pass.
  always_comb begin
    stack_we    = (state == sbm_pkg::S_WRITE) && exec_status == sbm_pkg::ST_RUNNING &&
                  (op == sbm_pkg::OP_PUSH || op == sbm_pkg::OP_DUP || op == sbm_pkg::OP_LOAD ||
                   op == sbm_pkg::OP_ADD || op == sbm_pkg::OP_SUB || op == sbm_pkg::OP_MUL ||
                   op == sbm_pkg::OP_DIV);
    stack_waddr = (op == sbm_pkg::OP_PUSH || op == sbm_pkg::OP_DUP || op == sbm_pkg::OP_LOAD) ?
                  SAW'(sp) : SAW'(sp - SPW'(2));
    stack_wdata = result;
    if (state == sbm_pkg::S_CLEAR) begin
      data_we    = 1'b1;
      data_waddr = clear_addr;
      data_wdata = 32'd0;
    end else begin
      data_we    = (state == sbm_pkg::S_WRITE) && exec_status == sbm_pkg::ST_RUNNING &&
                   op == sbm_pkg::OP_SAVE;
      data_waddr = DAW'(arg);
      data_wdata = top_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sbm_pkg::S_CLEAR;
      clear_addr     <= '0;
      read_phase     <= 1'b0;
      program_length <= sbm_pkg::PROGRAM_LENGTH_RESET;
      step_limit     <= sbm_pkg::STEP_LIMIT_RESET;
      ip             <= 9'd0;
      sp             <= '0;
      step_count     <= 16'd0;
      final_status   <= sbm_pkg::ST_RUNNING;
      out_valid      <= 1'b0;
      print_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == sbm_pkg::REG_PROGRAM_LENGTH) program_length <= cfg_data[8:0];
        else step_limit <= cfg_data;
      end
      if (state == sbm_pkg::S_CLEAR) clear_addr <= clear_addr + DAW'(1);
      if (state == sbm_pkg::S_IDLE && in_valid) begin
        op  <= opcode;
        arg <= operand;
        read_phase <= 1'b0;
      end
      if (state == sbm_pkg::S_READ) read_phase <= 1'b1;
      if (state == sbm_pkg::S_EXEC) begin
        print_valid <= 1'b0;
        print_value <= 32'sd0;
        if (final_status == sbm_pkg::ST_RUNNING) begin
          if (ip >= len) final_status <= sbm_pkg::ST_NO_HALT;
          else if (step_count >= step_limit) final_status <= sbm_pkg::ST_LIMIT;
          else step_count <= step_count + 16'd1;
        end
      end
      if (state == sbm_pkg::S_WRITE) begin
        final_status <= exec_status;
        ip <= ip_next;
        sp <= sp_next;
        print_valid <= pv_next;
        print_value <= pv_next ? top_q : 32'sd0;
      end
      if (state_next == sbm_pkg::S_OUT && state != sbm_pkg::S_OUT) out_valid <= 1'b1;
      if (state == sbm_pkg::S_OUT && out_ready) out_valid <= 1'b0;
    end
  end

  assign next_address = ip;
  assign status       = final_status;
  assign stopped      = final_status != sbm_pkg::ST_RUNNING;

endmodule
